[hdl/isls_pkg.sv]
// Shared constants, types and word conversion functions for the indexed shift-list store.
package isls_pkg;

    localparam int DEPTH       = 256;
    localparam int WORD_BITS   = 32;

    localparam int CMD_BITS    = 3;
    localparam int POS_BITS    = 8;
    localparam int DATA_BITS   = 32;
    localparam int STATUS_BITS = 2;

    localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int CMP_BITS    = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    // Read select tree: groups of up to 16 cells, then one pick among the groups.
    localparam int LO_BITS     = (IDX_BITS < 4) ? IDX_BITS : 4;
    localparam int HI_W        = (IDX_BITS > LO_BITS) ? (IDX_BITS - LO_BITS) : 1;
    localparam int GROUP_SIZE  = 1 << LO_BITS;
    localparam int NUM_GROUPS  = 1 << HI_W;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_READ_AT = 3'd5,
        CMD_FRONT   = 3'd6,
        CMD_BACK    = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_INSERT = 2'd2,
        OP_ERASE  = 2'd3
    } shift_op_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        shift_op_t             op;
        logic [IDX_BITS-1:0]   pos;
        logic [IDX_BITS-1:0]   tail;
    } shift_ctrl_t;

    // Sign-extend the 32-bit input word and keep its low WORD_BITS bits.
    function automatic word_t to_word(input logic signed [DATA_BITS-1:0] v);
        logic signed [63:0] v64;
        v64 = 64'(v);
        return v64[WORD_BITS-1:0];
    endfunction

    // Sign-extend a stored word and return its low 32 bits.
    function automatic logic signed [DATA_BITS-1:0] from_word(input word_t w);
        logic signed [63:0] w64;
        w64 = 64'(signed'(w));
        return w64[DATA_BITS-1:0];
    endfunction

endpackage

[hdl/isls_if.sv]
// Valid/ready channel interfaces for the command and response items.
interface isls_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [isls_pkg::CMD_BITS-1:0]          command;
    logic [isls_pkg::POS_BITS-1:0]          position;
    logic signed [isls_pkg::DATA_BITS-1:0]  value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface isls_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [isls_pkg::DATA_BITS-1:0]  read_value;
    logic [isls_pkg::STATUS_BITS-1:0]       status;
    logic [isls_pkg::CNT_BITS-1:0]          count_after;
    logic                                   is_empty;

    modport source (output valid, output read_value, output status,
                    output count_after, output is_empty, input ready);
    modport sink   (input valid, input read_value, input status,
                    input count_after, input is_empty, output ready);
endinterface

[hdl/isls_cell.sv]
// One storage cell of the shift chain: holds a word, loads new data or a neighbor's word.
module isls_cell (
    input  logic                               clk,
    input  isls_pkg::shift_ctrl_t              ctrl,
    input  logic [isls_pkg::IDX_BITS-1:0]      my_idx,
    input  isls_pkg::word_t                    left_word,
    input  isls_pkg::word_t                    right_word,
    input  isls_pkg::word_t                    new_word,
    output isls_pkg::word_t                    word
);

    isls_pkg::word_t word_reg;
    isls_pkg::word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            isls_pkg::OP_PUSH:
            begin
                if (my_idx == ctrl.tail)
                begin
                    word_next = new_word;
                end
            end
            isls_pkg::OP_INSERT:
            begin
                if (my_idx > ctrl.pos)
                begin
                    word_next = left_word;
                end
                else if (my_idx == ctrl.pos)
                begin
                    word_next = new_word;
                end
            end
            isls_pkg::OP_ERASE:
            begin
                if (my_idx >= ctrl.pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

[hdl/isls_read_sel.sv]
// Registered two-level read select: one word per group is captured, then one group is picked.
module isls_read_sel (
    input  logic                                clk,
    input  logic                                load,
    input  isls_pkg::word_t                     words [isls_pkg::NUM_GROUPS][isls_pkg::GROUP_SIZE],
    input  logic [isls_pkg::LO_BITS-1:0]        lo,
    input  logic [isls_pkg::HI_W-1:0]           hi,
    output isls_pkg::word_t                     sel_word
);

    isls_pkg::word_t group_reg [isls_pkg::NUM_GROUPS];

    for (genvar g = 0; g < isls_pkg::NUM_GROUPS; g++)
    begin : g_group
        always_ff @(posedge clk)
        begin
            if (load)
            begin
                group_reg[g] <= words[g][lo];
            end
        end
    end

    assign sel_word = group_reg[hi];

endmodule

[hdl/indexed_shift_list_store_core.sv]
// Top level of the indexed shift-list store: command decode, cell chain, read path, output register.
// Each result passes the stage-one register and then the output register; while the output register
// waits on rsp.ready, the next result is held in stage one.
// A new command item is not taken while one is in flight in stage one.
// Insert and erase update cells from the position on in parallel in the cycle the item is accepted.
// Reset (rst_n, asynchronous, active low) empties the list and the pipeline; the cell words
// are not cleared and stay undefined until written.
module indexed_shift_list_store_core (
    input  logic          clk,
    input  logic          rst_n,
    isls_cmd_if.sink      cmd,
    isls_rsp_if.source    rsp
);

    // ------------------------------------------------------------------
    // Control and pipeline registers
    // ------------------------------------------------------------------
    logic [isls_pkg::CNT_BITS-1:0]   count_reg;
    logic [isls_pkg::CNT_BITS-1:0]   count_next;

    logic                            s1_valid_reg;
    logic                            s1_read_reg;
    logic                            s1_ok_reg;
    isls_pkg::status_t               s1_status_reg;
    logic [isls_pkg::HI_W-1:0]       s1_hi_reg;

    logic                            out_valid_reg;
    logic signed [isls_pkg::DATA_BITS-1:0] out_value_reg;
    isls_pkg::status_t               out_status_reg;
    logic [isls_pkg::CNT_BITS-1:0]   out_count_reg;
    logic                            out_empty_reg;

    // ------------------------------------------------------------------
    // Decode of the accepted command
    // ------------------------------------------------------------------
    logic                            in_fire;
    logic                            s1_advance;
    isls_pkg::cmd_t                  cmd_code;
    logic [isls_pkg::CMP_BITS-1:0]   pos_cmp;
    logic [isls_pkg::CMP_BITS-1:0]   cnt_cmp;
    logic                            list_full;
    logic                            list_empty;
    isls_pkg::status_t               status_next;
    logic                            is_read;
    logic                            read_ok;
    logic [isls_pkg::IDX_BITS-1:0]   read_idx;
    isls_pkg::shift_ctrl_t           shift_ctrl;
    isls_pkg::word_t                 new_word;
    isls_pkg::word_t                 sel_word;

    // One item is in flight at a time; a finished result may still wait in the
    // output register while the next item is taken.
    assign cmd.ready  = !s1_valid_reg;
    assign in_fire    = cmd.valid && cmd.ready;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);

    assign cmd_code   = isls_pkg::cmd_t'(cmd.command);
    assign pos_cmp    = isls_pkg::CMP_BITS'(cmd.position);
    assign cnt_cmp    = isls_pkg::CMP_BITS'(count_reg);
    assign list_full  = (count_reg == isls_pkg::CNT_BITS'(isls_pkg::DEPTH));
    assign list_empty = (count_reg == '0);
    assign new_word   = isls_pkg::to_word(cmd.value);

    always_comb
    begin
        count_next      = count_reg;
        status_next     = isls_pkg::ST_OK;
        is_read         = 1'b0;
        read_ok         = 1'b0;
        read_idx        = '0;
        shift_ctrl.op   = isls_pkg::OP_NONE;
        shift_ctrl.pos  = isls_pkg::IDX_BITS'(cmd.position);
        shift_ctrl.tail = isls_pkg::IDX_BITS'(count_reg);
        case (cmd_code)
            isls_pkg::CMD_PUSH:
            begin
                if (list_full)
                begin
                    status_next = isls_pkg::ST_FULL;
                end
                else
                begin
                    shift_ctrl.op = isls_pkg::OP_PUSH;
                    count_next    = isls_pkg::CNT_BITS'(count_reg + 1'b1);
                end
            end
            isls_pkg::CMD_POP:
            begin
                if (list_empty)
                begin
                    status_next = isls_pkg::ST_BAD;
                end
                else
                begin
                    count_next = isls_pkg::CNT_BITS'(count_reg - 1'b1);
                end
            end
            isls_pkg::CMD_INSERT:
            begin
                // A full list is refused before the position is looked at.
                if (list_full)
                begin
                    status_next = isls_pkg::ST_FULL;
                end
                else if (pos_cmp > cnt_cmp)
                begin
                    status_next = isls_pkg::ST_BAD;
                end
                else
                begin
                    shift_ctrl.op = isls_pkg::OP_INSERT;
                    count_next    = isls_pkg::CNT_BITS'(count_reg + 1'b1);
                end
            end
            isls_pkg::CMD_ERASE:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    status_next = isls_pkg::ST_BAD;
                end
                else
                begin
                    shift_ctrl.op = isls_pkg::OP_ERASE;
                    count_next    = isls_pkg::CNT_BITS'(count_reg - 1'b1);
                end
            end
            isls_pkg::CMD_CLEAR:
            begin
                // The words stay in the cells but are no longer counted.
                count_next = '0;
            end
            isls_pkg::CMD_READ_AT:
            begin
                is_read  = 1'b1;
                read_ok  = (pos_cmp < cnt_cmp);
                read_idx = isls_pkg::IDX_BITS'(cmd.position);
            end
            isls_pkg::CMD_FRONT:
            begin
                is_read  = 1'b1;
                read_ok  = !list_empty;
                read_idx = '0;
            end
            isls_pkg::CMD_BACK:
            begin
                is_read  = 1'b1;
                read_ok  = !list_empty;
                read_idx = isls_pkg::IDX_BITS'(count_reg - 1'b1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (is_read && !read_ok)
        begin
            status_next = isls_pkg::ST_BAD;
        end
        // The chain only moves on the cycle an item is actually taken.
        if (!in_fire)
        begin
            shift_ctrl.op = isls_pkg::OP_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Chain of cells. Each cell sees its two neighbors; the ends see zero.
    // ------------------------------------------------------------------
    isls_pkg::word_t cell_word [isls_pkg::DEPTH];
    isls_pkg::word_t grid      [isls_pkg::NUM_GROUPS][isls_pkg::GROUP_SIZE];

    for (genvar i = 0; i < isls_pkg::DEPTH; i++)
    begin : g_cell
        isls_pkg::word_t left_w;
        isls_pkg::word_t right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_left
            assign left_w = cell_word[i-1];
        end

        if (i == isls_pkg::DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_right
            assign right_w = cell_word[i+1];
        end

        isls_cell u_cell (
            .clk        (clk),
            .ctrl       (shift_ctrl),
            .my_idx     (isls_pkg::IDX_BITS'(i)),
            .left_word  (left_w),
            .right_word (right_w),
            .new_word   (new_word),
            .word       (cell_word[i])
        );
    end

    // Arrange the cells as groups for the read path; slots past the end read as zero.
    for (genvar g = 0; g < isls_pkg::NUM_GROUPS; g++)
    begin : g_grid
        for (genvar k = 0; k < isls_pkg::GROUP_SIZE; k++)
        begin : g_slot
            if (g * isls_pkg::GROUP_SIZE + k < isls_pkg::DEPTH)
            begin : g_used
                assign grid[g][k] = cell_word[g * isls_pkg::GROUP_SIZE + k];
            end
            else
            begin : g_pad
                assign grid[g][k] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read path: group words are captured at accept, the group is picked
    // from the registered high index on the way into the output register.
    // Read commands never change the cells, so the capture sees the list
    // as it stood before the command.
    // ------------------------------------------------------------------
    isls_read_sel u_read_sel (
        .clk      (clk),
        .load     (in_fire),
        .words    (grid),
        .lo       (read_idx[isls_pkg::LO_BITS-1:0]),
        .hi       (s1_hi_reg),
        .sel_word (sel_word)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg    <= count_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_read_reg   <= is_read;
            s1_ok_reg     <= read_ok;
            s1_status_reg <= status_next;
            s1_hi_reg     <= isls_pkg::HI_W'(read_idx >> isls_pkg::LO_BITS);
        end

        if (s1_advance)
        begin
            if (!s1_read_reg)
            begin
                out_value_reg <= '0;
            end
            else if (s1_ok_reg)
            begin
                out_value_reg <= isls_pkg::from_word(sel_word);
            end
            else
            begin
                out_value_reg <= '1;
            end
            out_status_reg <= s1_status_reg;
            // No item is taken while one is in flight, so the count is this item's.
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.count_after = out_count_reg;
    assign rsp.is_empty    = out_empty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= isls_pkg::CNT_BITS'(isls_pkg::DEPTH))
        else $error("entry count beyond capacity");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(count_reg))
        else $error("entry count changed without an accepted item");

    a_full_status_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_status_reg == isls_pkg::ST_FULL)
            |-> (count_reg == isls_pkg::CNT_BITS'(isls_pkg::DEPTH)))
        else $error("full status reported on a list that is not full");

    a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |=> s1_valid_reg)
        else $error("item in flight dropped while the output stalled");

endmodule
